// ===== rtl/core/fjr_pkg.sv =====
// Shared types and codes for the feeder jam/reverse sequencer.
`default_nettype none

package fjr_pkg;

  // Mode request codes; anything above MODE_DEEP_EJECT acts as disabled.
  localparam logic [2:0] MODE_DISABLED   = 3'd0;
  localparam logic [2:0] MODE_FRICTION   = 3'd1;
  localparam logic [2:0] MODE_SINGLE     = 3'd2;
  localparam logic [2:0] MODE_AUTO       = 3'd3;
  localparam logic [2:0] MODE_EJECT      = 3'd4;
  localparam logic [2:0] MODE_DEEP_EJECT = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_WORKING_VEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_VEL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EJECT_VEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEEP_EJECT_VEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOT_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JAM_TIME       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EJECT_DUR      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEEP_EJECT_DUR = 3'd7;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic        [14:0] working_velocity;
    logic        [14:0] safe_velocity;
    logic signed [15:0] eject_velocity;
    logic signed [15:0] deep_eject_velocity;
    logic        [23:0] single_shot_timeout;
    logic        [23:0] jam_time;
    logic        [23:0] eject_duration;
    logic        [23:0] deep_eject_duration;
  } fjr_cfg_t;

  typedef struct packed {
    logic        [2:0]  mode_request;
    logic        [31:0] cmd_seq;
    logic               fric_ready;
    logic               shot_fired;
    logic        [7:0]  heat_budget;
    logic signed [15:0] meas_vel;
    logic        [15:0] tick_time;
  } fjr_item_t;

  typedef struct packed {
    logic signed [15:0] feeder_command;
    logic               jam_event;
    logic               ejecting;
  } fjr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/fjr_cfg.sv =====
// Configuration register bank of the feeder jam/reverse sequencer.
`default_nettype none

module fjr_cfg
  import fjr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output fjr_cfg_t                   cfg
);

  fjr_cfg_t cfg_r;
  fjr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_WORKING_VEL:    cfg_nxt.working_velocity    = wr_data[14:0];
        REG_SAFE_VEL:       cfg_nxt.safe_velocity       = wr_data[14:0];
        REG_EJECT_VEL:      cfg_nxt.eject_velocity      = signed'(wr_data[15:0]);
        REG_DEEP_EJECT_VEL: cfg_nxt.deep_eject_velocity = signed'(wr_data[15:0]);
        REG_SHOT_TIMEOUT:   cfg_nxt.single_shot_timeout = wr_data;
        REG_JAM_TIME:       cfg_nxt.jam_time            = wr_data;
        REG_EJECT_DUR:      cfg_nxt.eject_duration      = wr_data;
        REG_DEEP_EJECT_DUR: cfg_nxt.deep_eject_duration = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/fjr_core.sv =====
// Sequencer state and single-pass step logic of the feeder jam/reverse sequencer.
`default_nettype none

module fjr_core
  import fjr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step_en,
  input  fjr_item_t item,
  input  fjr_cfg_t  cfg,
  output fjr_result_t result
);

  localparam logic signed [26:0] TMR_MAX_EXT = 27'sd33554431;
  localparam logic signed [26:0] TMR_MIN_EXT = -27'sd33554432;

  function automatic logic signed [25:0] clamp_tmr(input logic signed [26:0] v);
    logic signed [25:0] r;
    if (v > TMR_MAX_EXT) begin
      r = {1'b0, {25{1'b1}}};
    end else if (v < TMR_MIN_EXT) begin
      r = {1'b1, {25{1'b0}}};
    end else begin
      r = v[25:0];
    end
    return r;
  endfunction

  logic signed [25:0] tmr_r,  tmr_nxt;
  logic        [1:0]  jams_r, jams_nxt;
  logic        [23:0] etl_r,  etl_nxt;
  logic signed [15:0] arv_r,  arv_nxt;
  logic               ssp_r,  ssp_nxt;
  logic        [23:0] sst_r,  sst_nxt;
  logic signed [15:0] pcmd_r, pcmd_nxt;
  logic        [2:0]  pmode_r, pmode_nxt;
  logic        [31:0] pseq_r, pseq_nxt;

  always_comb begin
    logic        [2:0]  mode_v;
    logic               evt_v;
    logic               chg_v;
    logic        [14:0] want_v;
    logic        [24:0] sst_sum_v;
    logic        [23:0] sst_sat_v;
    logic signed [16:0] meas_v;
    logic        [16:0] mag_v;
    logic signed [26:0] tmr_v;
    logic signed [26:0] jt_v;
    logic signed [26:0] dt_v;
    logic               jam_v;
    logic        [1:0]  jcnt_v;
    logic               deep_v;
    logic signed [15:0] cmd_v;
    logic               ej_v;

    tmr_nxt   = tmr_r;
    jams_nxt  = jams_r;
    etl_nxt   = etl_r;
    arv_nxt   = arv_r;
    ssp_nxt   = ssp_r;
    sst_nxt   = sst_r;
    pmode_nxt = pmode_r;
    pseq_nxt  = pseq_r;

    want_v    = '0;
    cmd_v     = '0;
    jam_v     = 1'b0;
    ej_v      = 1'b0;
    sst_sum_v = '0;
    sst_sat_v = '0;
    tmr_v     = '0;
    jcnt_v    = '0;
    deep_v    = 1'b0;
    jt_v      = signed'({3'b000, cfg.jam_time});
    dt_v      = signed'({11'd0, item.tick_time});
    meas_v    = {item.meas_vel[15], item.meas_vel};
    mag_v     = meas_v[16] ? 17'(-meas_v) : 17'(meas_v);

    // Fold unknown mode codes onto disabled.
    mode_v = (item.mode_request > MODE_DEEP_EJECT) ? MODE_DISABLED : item.mode_request;
    evt_v  = (item.cmd_seq != '0) && (item.cmd_seq != pseq_r);
    chg_v  = (mode_v != pmode_r);

    if (evt_v) begin
      pseq_nxt = item.cmd_seq;
    end
    if ((mode_v != MODE_SINGLE) || item.shot_fired) begin
      ssp_nxt = 1'b0;
    end
    if (mode_v == MODE_DISABLED) begin
      jams_nxt = '0;
      etl_nxt  = '0;
    end
    if (evt_v || chg_v) begin
      if (mode_v == MODE_SINGLE) begin
        ssp_nxt = 1'b1;
        sst_nxt = '0;
      end else if (mode_v == MODE_EJECT) begin
        arv_nxt = cfg.eject_velocity;
        etl_nxt = cfg.eject_duration;
      end else if (mode_v == MODE_DEEP_EJECT) begin
        arv_nxt = cfg.deep_eject_velocity;
        etl_nxt = cfg.deep_eject_duration;
      end
      pmode_nxt = mode_v;
    end

    if (etl_nxt != '0) begin
      // Running eject phase wins; count its time down, saturating at zero.
      etl_nxt = (etl_nxt > {8'd0, item.tick_time}) ? (etl_nxt - {8'd0, item.tick_time}) : '0;
      tmr_nxt = '0;
      cmd_v   = arv_nxt;
      ej_v    = 1'b1;
    end else if (!item.fric_ready) begin
      tmr_nxt = '0;
    end else begin
      if ((mode_v == MODE_AUTO) && (item.heat_budget != '0)) begin
        want_v = (item.heat_budget > 8'd1) ? cfg.working_velocity : cfg.safe_velocity;
      end else if ((mode_v == MODE_SINGLE) && ssp_nxt) begin
        sst_sum_v = {1'b0, sst_nxt} + {9'd0, item.tick_time};
        sst_sat_v = sst_sum_v[24] ? {24{1'b1}} : sst_sum_v[23:0];
        sst_nxt   = sst_sat_v;
        if (sst_sat_v <= cfg.single_shot_timeout) begin
          if (item.heat_budget != '0) begin
            want_v = cfg.safe_velocity;
          end
        end else begin
          ssp_nxt = 1'b0;
        end
      end

      if (want_v == '0) begin
        tmr_nxt = '0;
      end else begin
        // Speed step-up restarts a running run timer.
        if ((signed'({1'b0, want_v}) > pcmd_r) && (tmr_nxt > 26'sd0)) begin
          tmr_nxt = '0;
        end
        tmr_v = {tmr_nxt[25], tmr_nxt};
        if ({mag_v, 1'b0} >= {3'd0, want_v}) begin
          // Feeder keeps up: count run time, drop the jam streak once settled.
          if (tmr_v < 27'sd0) begin
            tmr_nxt = '0;
          end else if (tmr_v < jt_v) begin
            tmr_nxt = clamp_tmr(tmr_v + dt_v);
          end else begin
            jams_nxt = '0;
          end
        end else if (tmr_v >= jt_v) begin
          jam_v = 1'b1;
        end else if (tmr_v > 27'sd0) begin
          tmr_nxt = '0;
        end else if (tmr_v > -jt_v) begin
          tmr_nxt = clamp_tmr(tmr_v - dt_v);
        end else begin
          jam_v = 1'b1;
        end

        if (jam_v) begin
          jcnt_v   = (jams_nxt == 2'd3) ? 2'd3 : (jams_nxt + 2'd1);
          deep_v   = (jcnt_v == 2'd3);
          jams_nxt = jcnt_v;
          arv_nxt  = deep_v ? cfg.deep_eject_velocity : cfg.eject_velocity;
          etl_nxt  = deep_v ? cfg.deep_eject_duration : cfg.eject_duration;
          ssp_nxt  = 1'b0;
          tmr_nxt  = '0;
          cmd_v    = arv_nxt;
          ej_v     = 1'b1;
        end else begin
          cmd_v = signed'({1'b0, want_v});
        end
      end
    end

    pcmd_nxt = cmd_v;
    result.feeder_command = cmd_v;
    result.jam_event      = jam_v;
    result.ejecting       = ej_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_r   <= '0;
      jams_r  <= '0;
      etl_r   <= '0;
      arv_r   <= '0;
      ssp_r   <= 1'b0;
      sst_r   <= '0;
      pcmd_r  <= '0;
      pmode_r <= MODE_DISABLED;
      pseq_r  <= '0;
    end else if (step_en) begin
      tmr_r   <= tmr_nxt;
      jams_r  <= jams_nxt;
      etl_r   <= etl_nxt;
      arv_r   <= arv_nxt;
      ssp_r   <= ssp_nxt;
      sst_r   <= sst_nxt;
      pcmd_r  <= pcmd_nxt;
      pmode_r <= pmode_nxt;
      pseq_r  <= pseq_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/feeder_jam_reverse_sequencer.sv =====
// Top level of the feeder jam/reverse sequencer: beat registers, config bank and step logic.
`default_nettype none

// Feeder jam/reverse sequencer. Each input beat is one control tick: mode request,
// command sequence number, friction-ready and bullet-fired flags, heat allowance,
// measured feeder velocity (signed Q8.8 rad/s) and elapsed time in microseconds.
// Each tick yields exactly one output beat with the feeder velocity command, a jam
// flag and an ejecting flag. The block sustains one beat per clock while the output is
// drained: a beat lands in the input register, passes the step logic, and updates the
// sequencer state and the output register together at the edge where it advances, so
// out_tvalid rises at the edge after the input accept edge unless a stalled output
// holds the beat. The loop from the state registers through the step logic back into
// them sets the rate. The output register decouples the two sides: a new input beat
// is taken while a finished result waits, and only a full input register behind a
// stalled output holds in_tready low. Configuration writes (index 0..7 in the register
// order working, safe, eject, deep eject velocity, single-shot timeout, jam time, eject
// and deep eject duration) are always ready and must be issued while no tick is in flight.

module feeder_jam_reverse_sequencer
  import fjr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input beats
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [2:0] mode_request, [34:3] cmd_seq, [35] fric_ready,
  // [36] shot_fired, [44:37] heat_budget, [60:45] meas_vel,
  // [76:61] tick_time, [79:77] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // result beats
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] feeder_command, [16] jam_event, [17] ejecting, [23:18] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  fjr_cfg_t    cfg;
  fjr_item_t   item_r;
  fjr_result_t result;
  logic        in_vld_r;
  logic        out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic        advance;

  // Config bank never stalls a write.
  assign cfg_ready = 1'b1;

  fjr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held tick whenever the output register is free or being drained.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // Unpack the input beat; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode_request <= in_tdata[2:0];
      item_r.cmd_seq      <= in_tdata[34:3];
      item_r.fric_ready   <= in_tdata[35];
      item_r.shot_fired   <= in_tdata[36];
      item_r.heat_budget  <= in_tdata[44:37];
      item_r.meas_vel     <= signed'(in_tdata[60:45]);
      item_r.tick_time    <= in_tdata[76:61];
    end
  end

  fjr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register: load on advance, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, result.ejecting, result.jam_event, result.feeder_command};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // A jam always starts an eject, so it is flagged as ejecting.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[16]) |-> out_tdata[17])
    else $error("jam_event without ejecting");

  // Input only stalls behind a full input register and a blocked output.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_tvalid && !out_tready))
    else $error("input stalled without back-pressure");

  // Every processed tick shows up as a result beat next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("processed tick lost");

endmodule

`default_nettype wire
